// File: design/i2dd_pkg.sv
// Shared types and constants for the binary to decimal digit formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2dd_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int VALUE_W    = 31;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int CNT_W      = $clog2(VALUE_W);

  localparam logic [3:0]       MAX_DIGITS_W = 4'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] LAST_SHIFT   = CNT_W'(VALUE_W - 1);

  localparam logic [1:0] ALIGN_LEFT  = 2'd0;
  localparam logic [1:0] ALIGN_RIGHT = 2'd1;
  localparam logic [1:0] ALIGN_ZERO  = 2'd2;

  typedef enum logic [1:0] {
    KIND_DIGIT = 2'd0,
    KIND_SPACE = 2'd1,
    KIND_OVF   = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CNV_IDLE,
    CNV_SHIFT,
    CNV_DONE
  } cnv_state_e;

  typedef enum logic [1:0] {
    EMT_IDLE,
    EMT_DIGITS,
    EMT_END
  } emt_state_e;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic       valid;
    bcd_t       bcd;
    logic [3:0] width;
    logic [1:0] mode;
  } cnv_res_t;

endpackage

`default_nettype wire

// File: design/int_to_decimal_digits_top.sv
// Top level of the binary to decimal digit formatter.
// Depends on i2dd_pkg, i2dd_dabble and i2dd_emit.
//
// Slave stream: one transfer carries value, digit_count and align_mode.
// Master stream: one transfer per character, most significant position
// first; tuser gives the kind (digit, space, overflow mark, end marker),
// tdata the digit, tlast marks the end marker that closes each input.
// The converter shifts one value bit per cycle through its 31 steps, and the
// sequencer then loads the digits; after the first character, characters
// follow one per cycle while the receiver is ready (left mode emits nothing
// while it skips a dropped leading zero). The 31-step bit-serial converter
// limits how often inputs are taken; the next input converts while the
// previous one is written out.
// Reset clears both state machines and the output valid; nothing is pending.
// When the receiver stalls, the output register holds its character and the
// sequencer waits; the converter finishes and holds its result, and no new
// input is accepted until the sequencer takes that result.
`default_nettype none

module int_to_decimal_digits_top import i2dd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [30:0] value, [34:31] digit_count, [36:35] align_mode, [39:37] zero
  input  wire logic [39:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [3:0] digit_value, [7:4] zero
  output logic [7:0]       m_axis_tdata_o,
  // [1:0] char_kind
  output logic [1:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  cnv_res_t res;
  logic take;
  logic cnv_ready;
  kind_e kind;
  logic [3:0] digit;

  i2dd_dabble u_dabble (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (s_axis_tvalid_i),
    .ready_o       (cnv_ready),
    .value_i       (s_axis_tdata_i[VALUE_W-1:0]),
    .digit_count_i (s_axis_tdata_i[34:31]),
    .align_mode_i  (s_axis_tdata_i[36:35]),
    .res_o         (res),
    .take_i        (take)
  );

  i2dd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .kind_o      (kind),
    .digit_o     (digit),
    .last_o      (m_axis_tlast_o)
  );

  assign s_axis_tready_o = cnv_ready;
  assign m_axis_tdata_o  = {4'd0, digit};
  assign m_axis_tuser_o  = kind;

endmodule

`default_nettype wire

// File: design/i2dd_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on i2dd_pkg; feeds i2dd_emit through a cnv_res_t handoff.
`default_nettype none

module i2dd_dabble import i2dd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    ready_o,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic [3:0]         digit_count_i,
  input  wire logic [1:0]         align_mode_i,
  output cnv_res_t                res_o,
  input  wire logic               take_i
);

  cnv_state_e state_q, state_d;
  logic [VALUE_W-1:0] bin_q, bin_d;
  bcd_t bcd_q, bcd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0] width_q, width_d;
  logic [1:0] mode_q, mode_d;
  bcd_t adj;
  logic [BCD_W-1:0] adj_flat;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end
  assign adj_flat = adj;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CNV_IDLE: begin
        if (start_i) state_d = CNV_SHIFT;
      end
      CNV_SHIFT: begin
        if (cnt_q == LAST_SHIFT) state_d = CNV_DONE;
      end
      CNV_DONE: begin
        if (take_i) state_d = CNV_IDLE;
      end
      default: state_d = CNV_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    width_d = width_q;
    mode_d  = mode_q;
    if (state_q == CNV_IDLE && start_i) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = '0;
      mode_d = align_mode_i;
      if (digit_count_i == 4'd0) begin
        width_d = 4'd1;
      end else if (digit_count_i > MAX_DIGITS_W) begin
        width_d = MAX_DIGITS_W;
      end else begin
        width_d = digit_count_i;
      end
    end else if (state_q == CNV_SHIFT) begin
      bcd_d = bcd_t'({adj_flat[BCD_W-2:0], bin_q[VALUE_W-1]});
      bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // outputs
  always_comb begin
    ready_o     = (state_q == CNV_IDLE);
    res_o.valid = (state_q == CNV_DONE);
    res_o.bcd   = bcd_q;
    res_o.width = width_q;
    res_o.mode  = mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CNV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    width_q <= width_d;
    mode_q  <= mode_d;
  end

endmodule

`default_nettype wire

// File: design/i2dd_emit.sv
// Character sequencer: walks the BCD digits from the leading field position
// down, applies alignment and overflow, and drives the registered output.
// Depends on i2dd_pkg; takes its work from i2dd_dabble.
`default_nettype none

module i2dd_emit import i2dd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cnv_res_t res_i,
  output logic          take_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output kind_e         kind_o,
  output logic [3:0]    digit_o,
  output logic          last_o
);

  emt_state_e state_q, state_d;
  bcd_t bcd_q;
  logic [3:0] pos_q;
  logic writing_q, spaces_q, first_q, ovf_q;
  logic out_valid_q;
  kind_e kind_q;
  logic [3:0] dig_q;
  logic last_q;

  logic can_push;
  logic load;
  logic ovf_in;
  logic [3:0] cur;
  logic emit;
  kind_e emit_kind;
  logic [3:0] emit_dig;

  assign can_push = !out_valid_q || out_ready_i;
  assign load     = (state_q == EMT_IDLE) && res_i.valid;
  assign cur      = bcd_q[pos_q];

  always_comb begin
    ovf_in = 1'b0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (4'(i) >= res_i.width && res_i.bcd[i] != 4'd0) ovf_in = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      EMT_IDLE: begin
        if (res_i.valid) state_d = EMT_DIGITS;
      end
      EMT_DIGITS: begin
        if (can_push && pos_q == 4'd0) state_d = EMT_END;
      end
      EMT_END: begin
        if (can_push) state_d = EMT_IDLE;
      end
      default: state_d = EMT_IDLE;
    endcase
  end

  // character selection
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_DIGIT;
    emit_dig  = 4'd0;
    case (state_q)
      EMT_DIGITS: begin
        if (first_q && ovf_q) begin
          emit      = can_push;
          emit_kind = KIND_OVF;
        end else if (writing_q || cur != 4'd0 || pos_q == 4'd0) begin
          emit      = can_push;
          emit_dig  = cur;
        end else if (spaces_q) begin
          emit      = can_push;
          emit_kind = KIND_SPACE;
        end
      end
      EMT_END: begin
        emit      = can_push;
        emit_kind = KIND_END;
      end
      default: emit = 1'b0;
    endcase
  end

  assign take_o      = load;
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign digit_o     = dig_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EMT_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q     <= res_i.bcd;
      pos_q     <= res_i.width - 4'd1;
      writing_q <= (res_i.mode == ALIGN_ZERO);
      spaces_q  <= (res_i.mode == ALIGN_RIGHT);
      first_q   <= 1'b1;
      ovf_q     <= ovf_in;
    end else if (state_q == EMT_DIGITS && can_push) begin
      first_q <= 1'b0;
      if (emit && emit_kind != KIND_SPACE) writing_q <= 1'b1;
      if (pos_q != 4'd0) pos_q <= pos_q - 4'd1;
    end
    if (emit) begin
      kind_q <= emit_kind;
      dig_q  <= emit_dig;
      last_q <= (emit_kind == KIND_END);
    end
  end

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> kind_q == KIND_END)
    else $error("last flag on a non-end character");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_DIGIT |-> dig_q <= 4'd9)
    else $error("digit above nine");

  a_nondigit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != KIND_DIGIT |-> dig_q == 4'd0)
    else $error("non-digit character carries a digit value");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == EMT_END && can_push |=> state_q == EMT_IDLE && out_valid_q && last_q)
    else $error("end marker not issued when leaving the run");

endmodule

`default_nettype wire
